@@ hw/rtl/udsrch_pkg.sv @@
package udsrch_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_END_LO,
    S_END_HI,
    S_WALK,
    S_TYPE,
    S_IFN,
    S_ALT,
    S_LEN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_FIND,
    PH_COUNT,
    PH_SEARCH,
    PH_CSEP
  } phase_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] QK_INTERFACE   = 2'd0;
  localparam logic [1:0] QK_ENDPOINT    = 2'd1;
  localparam logic [1:0] QK_CS_ENDPOINT = 2'd2;
  localparam logic [1:0] QK_CS_IFACE    = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd2;

  localparam logic [7:0] DT_INTERFACE    = 8'h04;
  localparam logic [7:0] DT_ENDPOINT     = 8'h05;
  localparam logic [7:0] DT_CS_INTERFACE = 8'h24;
  localparam logic [7:0] DT_CS_ENDPOINT  = 8'h25;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic       opcode;
    logic [9:0] byte_address;
    logic [7:0] byte_value;
    logic [1:0] query_kind;
    logic [7:0] interface_number;
    logic [7:0] alt_setting;
    logic [7:0] target_index;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] desc_offset;
    logic [7:0] desc_length;
    logic [7:0] cs_interface_count;
  } result_t;

endpackage

@@ hw/rtl/udsrch_ram.sv @@
module udsrch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/udsrch_walker.sv @@
module udsrch_walker #(
  parameter int MAX_CONFIG_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  udsrch_pkg::item_t  item,
  output logic               res_valid,
  input  logic               res_ready,
  output udsrch_pkg::result_t res
);

  localparam int AW = $clog2(MAX_CONFIG_BYTES);
  localparam int PW = $clog2(MAX_CONFIG_BYTES + 512);
  localparam logic [PW-1:0] MAXP = PW'(MAX_CONFIG_BYTES);

  udsrch_pkg::state_t  state_r, state_nxt;
  udsrch_pkg::phase_t  phase_r, phase_nxt;
  udsrch_pkg::item_t   q_r, q_nxt;
  udsrch_pkg::result_t res_r, res_nxt;

  logic [PW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] end_r, end_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [7:0]    plen_r, plen_nxt;
  logic [7:0]    end_lo_r, end_lo_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic          match_r, match_nxt;
  logic          oor_r;

  logic [PW-1:0] rd_addr;
  logic          rd_oor;
  logic [7:0]    ram_rdata;
  logic [7:0]    rbyte;
  logic          mem_we;
  logic          accept;
  logic          bound_fail;
  logic          len_zero;
  logic [7:0]    want;
  logic [PW-1:0] cur_adv;
  logic [15:0]   end_raw;

  logic          fin;
  logic [1:0]    fin_status;
  logic [PW-1:0] fin_off;
  logic [7:0]    fin_len;
  logic [7:0]    fin_cnt;

  assign item_ready = (state_r == udsrch_pkg::S_IDLE);
  assign accept     = item_valid && item_ready;
  assign mem_we     = accept && (item.opcode == udsrch_pkg::OP_WRITE) &&
                      ({22'd0, item.byte_address} < 32'(MAX_CONFIG_BYTES));

  assign rd_oor     = (32'(rd_addr) >= 32'(MAX_CONFIG_BYTES));
  assign rbyte      = oor_r ? 8'd0 : ram_rdata;
  assign bound_fail = (cur_r + PW'(2)) > end_r;
  assign len_zero   = (rbyte == 8'd0);
  assign cur_adv    = cur_r + PW'(rbyte);
  assign want       = (q_r.query_kind == udsrch_pkg::QK_CS_IFACE) ?
                      udsrch_pkg::DT_CS_INTERFACE : udsrch_pkg::DT_ENDPOINT;
  assign end_raw    = {rbyte, end_lo_r};

  udsrch_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CONFIG_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(item.byte_address)),
    .wdata (item.byte_value),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= udsrch_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oor_r    <= rd_oor;
    phase_r  <= phase_nxt;
    q_r      <= q_nxt;
    res_r    <= res_nxt;
    cur_r    <= cur_nxt;
    end_r    <= end_nxt;
    p_r      <= p_nxt;
    plen_r   <= plen_nxt;
    end_lo_r <= end_lo_nxt;
    type_r   <= type_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    match_r  <= match_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      udsrch_pkg::S_IDLE: begin
        if (accept && item.opcode == udsrch_pkg::OP_QUERY) begin
          state_nxt = udsrch_pkg::S_END_LO;
        end
      end
      udsrch_pkg::S_END_LO: state_nxt = udsrch_pkg::S_END_HI;
      udsrch_pkg::S_END_HI: state_nxt = udsrch_pkg::S_WALK;
      udsrch_pkg::S_WALK:   state_nxt = fin ? udsrch_pkg::S_DONE : udsrch_pkg::S_TYPE;
      udsrch_pkg::S_TYPE: begin
        if (fin) begin
          state_nxt = udsrch_pkg::S_DONE;
        end else if (phase_r == udsrch_pkg::PH_FIND) begin
          state_nxt = udsrch_pkg::S_IFN;
        end else begin
          state_nxt = udsrch_pkg::S_LEN;
        end
      end
      udsrch_pkg::S_IFN:    state_nxt = udsrch_pkg::S_ALT;
      udsrch_pkg::S_ALT:    state_nxt = udsrch_pkg::S_LEN;
      udsrch_pkg::S_LEN:    state_nxt = fin ? udsrch_pkg::S_DONE : udsrch_pkg::S_WALK;
      udsrch_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = udsrch_pkg::S_IDLE;
        end
      end
      default: state_nxt = udsrch_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr    = cur_r + PW'(1);
    phase_nxt  = phase_r;
    q_nxt      = q_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    p_nxt      = p_r;
    plen_nxt   = plen_r;
    end_lo_nxt = end_lo_r;
    type_nxt   = type_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    match_nxt  = match_r;
    fin        = 1'b0;
    fin_status = udsrch_pkg::ST_NOT_FOUND;
    fin_off    = cur_r;
    fin_len    = rbyte;
    fin_cnt    = 8'd0;

    case (state_r)
      udsrch_pkg::S_IDLE: begin
        rd_addr = PW'(2);
        if (accept) begin
          q_nxt = item;
        end
      end
      udsrch_pkg::S_END_LO: begin
        rd_addr    = PW'(3);
        end_lo_nxt = rbyte;
      end
      udsrch_pkg::S_END_HI: begin
        if ({16'd0, end_raw} > 32'(MAX_CONFIG_BYTES)) begin
          end_nxt = MAXP;
        end else begin
          end_nxt = PW'(end_raw);
        end
        cur_nxt   = '0;
        phase_nxt = udsrch_pkg::PH_FIND;
        idx_nxt   = 8'd0;
        cnt_nxt   = 8'd0;
      end
      udsrch_pkg::S_WALK: begin
        if (bound_fail) begin
          fin = 1'b1;
          case (phase_r)
            udsrch_pkg::PH_FIND: fin_status = udsrch_pkg::ST_UNSUPPORTED;
            udsrch_pkg::PH_COUNT: begin
              fin_status = udsrch_pkg::ST_OK;
              fin_off    = p_r;
              fin_len    = plen_r;
              fin_cnt    = cnt_r;
            end
            default: fin_status = udsrch_pkg::ST_NOT_FOUND;
          endcase
        end
      end
      udsrch_pkg::S_TYPE: begin
        type_nxt = rbyte;
        rd_addr  = cur_r;
        case (phase_r)
          udsrch_pkg::PH_FIND: rd_addr = cur_r + PW'(2);
          udsrch_pkg::PH_COUNT: begin
            if (rbyte == udsrch_pkg::DT_INTERFACE) begin
              fin        = 1'b1;
              fin_status = udsrch_pkg::ST_OK;
              fin_off    = p_r;
              fin_len    = plen_r;
              fin_cnt    = cnt_r;
            end else if (rbyte == udsrch_pkg::DT_CS_INTERFACE && cnt_r != udsrch_pkg::CNT_MAX) begin
              cnt_nxt = cnt_r + 8'd1;
            end
          end
          udsrch_pkg::PH_SEARCH: begin
            fin = (rbyte == udsrch_pkg::DT_INTERFACE);
          end
          udsrch_pkg::PH_CSEP: begin
            fin = (rbyte != udsrch_pkg::DT_CS_ENDPOINT);
          end
          default: fin = 1'b0;
        endcase
      end
      udsrch_pkg::S_IFN: begin
        rd_addr   = cur_r + PW'(3);
        match_nxt = (type_r == udsrch_pkg::DT_INTERFACE) && (rbyte == q_r.interface_number);
      end
      udsrch_pkg::S_ALT: begin
        rd_addr   = cur_r;
        match_nxt = match_r && (rbyte == q_r.alt_setting);
      end
      udsrch_pkg::S_LEN: begin
        case (phase_r)
          udsrch_pkg::PH_FIND: begin
            if (len_zero) begin
              fin = 1'b1;
            end else begin
              cur_nxt = cur_adv;
              if (match_r) begin
                p_nxt     = cur_r;
                plen_nxt  = rbyte;
                phase_nxt = (q_r.query_kind == udsrch_pkg::QK_INTERFACE) ?
                            udsrch_pkg::PH_COUNT : udsrch_pkg::PH_SEARCH;
              end
            end
          end
          udsrch_pkg::PH_COUNT: begin
            fin     = len_zero;
            cur_nxt = cur_adv;
          end
          udsrch_pkg::PH_SEARCH: begin
            if (type_r == want && idx_r == q_r.target_index) begin
              if (q_r.query_kind != udsrch_pkg::QK_CS_ENDPOINT) begin
                fin        = 1'b1;
                fin_status = udsrch_pkg::ST_OK;
              end else begin
                fin       = len_zero;
                cur_nxt   = cur_adv;
                phase_nxt = udsrch_pkg::PH_CSEP;
              end
            end else begin
              if (type_r == want) begin
                idx_nxt = idx_r + 8'd1;
              end
              fin     = len_zero;
              cur_nxt = cur_adv;
            end
          end
          udsrch_pkg::PH_CSEP: begin
            fin        = 1'b1;
            fin_status = udsrch_pkg::ST_OK;
          end
          default: fin = 1'b0;
        endcase
      end
      default: rd_addr = cur_r;
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    if (fin) begin
      res_nxt.status = fin_status;
      if (fin_status == udsrch_pkg::ST_OK) begin
        res_nxt.desc_offset        = fin_off[9:0];
        res_nxt.desc_length        = fin_len;
        res_nxt.cs_interface_count = fin_cnt;
      end else begin
        res_nxt.desc_offset        = 10'd0;
        res_nxt.desc_length        = 8'd0;
        res_nxt.cs_interface_count = 8'd0;
      end
    end
  end

  assign res_valid = (state_r == udsrch_pkg::S_DONE);
  assign res       = res_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_r.status != udsrch_pkg::ST_OK |->
      res_r.desc_offset == 10'd0 && res_r.desc_length == 8'd0 &&
      res_r.cs_interface_count == 8'd0)
    else $error("failed query carries a non-zero payload");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == udsrch_pkg::S_IDLE)
    else $error("store written during a walk");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == udsrch_pkg::S_LEN && !fin && !len_zero |=> cur_r > $past(cur_r))
    else $error("walk failed to advance");

  a_count_kind: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_r.cs_interface_count != 8'd0 |->
      q_r.query_kind == udsrch_pkg::QK_INTERFACE)
    else $error("class-specific count on a non-interface query");

endmodule

@@ hw/rtl/usb_descriptor_search.sv @@
// Searches a USB configuration descriptor blob held in an internal byte store.
// Input transactions on the in_ channel either write one blob byte (opcode 0)
// or run a query (opcode 1) for an interface, its Nth endpoint, the
// class-specific endpoint after the Nth endpoint, or its Nth class-specific
// interface descriptor. A write gives no result. A query
// gives exactly one transaction on the out_ channel with a status and the
// offset and length of the descriptor found.
// Query time is set by the single read port of the byte store: a query
// fetches wTotalLength, visits each descriptor while looking for the
// interface, then each descriptor after it, and its result then passes
// into the output register.
// One query is in progress at a time; in_tready is low while it walks.
// Reset clears the control state only; the store contents stay undefined
// until written. If the receiver stalls, the result waits in the output
// register and new transactions are still accepted; a second finished result
// then waits in the search engine until the register frees.
module usb_descriptor_search #(
  parameter int MAX_CONFIG_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // byte_address, byte_value, interface_number, alt_setting, target_index
  input  logic [47:0] in_tdata,
  // opcode, query_kind
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // desc_offset, desc_length, cs_interface_count
  output logic [31:0] out_tdata,
  // status
  output logic [1:0]  out_tuser
);

  udsrch_pkg::item_t   item;
  udsrch_pkg::result_t res;
  udsrch_pkg::result_t out_r;
  logic                res_valid;
  logic                res_ready;
  logic                out_valid_r, out_valid_nxt;

  assign item.opcode           = in_tuser[0];
  assign item.query_kind       = in_tuser[2:1];
  assign item.byte_address     = in_tdata[9:0];
  assign item.byte_value       = in_tdata[17:10];
  assign item.interface_number = in_tdata[25:18];
  assign item.alt_setting      = in_tdata[33:26];
  assign item.target_index     = in_tdata[41:34];

  udsrch_walker #(
    .MAX_CONFIG_BYTES (MAX_CONFIG_BYTES)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {6'd0, out_r.cs_interface_count, out_r.desc_length, out_r.desc_offset};

endmodule
